>>> design/r2e_pkg.sv
`timescale 1ns / 1ps
package r2e_pkg;

	localparam int MW = 16;
	localparam int VW = 37;
	localparam int RW = 34;
	localparam int ZW = 28;
	localparam int CW = 19;
	localparam int AW = 18;
	localparam int PW = MW + CW;
	localparam int TAB_LEN = 24;

	localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [RW-1:0] KINV_Q30 = 34'sd652032875;
	localparam logic signed [AW-1:0] PI_Q13 = 18'sd25736;
	localparam logic signed [AW-1:0] TWO_PI_Q13 = 18'sd51472;

	localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
		28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
		28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32,
		28'sd16, 28'sd8, 28'sd4, 28'sd2
	};

	typedef struct packed {
		logic signed [MW-1:0] r00;
		logic signed [MW-1:0] r01;
		logic signed [MW-1:0] r02;
		logic signed [MW-1:0] r10;
		logic signed [MW-1:0] r11;
		logic signed [MW-1:0] r12;
		logic signed [MW-1:0] r20;
	} mat_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

endpackage

>>> design/r2e_cordic.sv
`timescale 1ns / 1ps
module r2e_cordic #(
	parameter int STAGES = 16,
	parameter int W = 37,
	parameter int TW = 1,
	parameter bit ROTATE = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic signed [W-1:0]           x_in,
	input  logic signed [W-1:0]           y_in,
	input  logic signed [r2e_pkg::ZW-1:0] z_in,
	input  logic [TW-1:0]                 tag_in,
	output logic                          vld_out,
	output logic signed [W-1:0]           x_out,
	output logic signed [W-1:0]           y_out,
	output logic signed [r2e_pkg::ZW-1:0] z_out,
	output logic [TW-1:0]                 tag_out
);
	import r2e_pkg::*;

	logic                 vld_s [STAGES+1];
	logic signed [W-1:0]  x_s   [STAGES+1];
	logic signed [W-1:0]  y_s   [STAGES+1];
	logic signed [ZW-1:0] z_s   [STAGES+1];
	logic [TW-1:0]        tag_s [STAGES+1];

	assign vld_s[0] = vld_in;
	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		logic                op;

		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign op = ROTATE ? ~z_s[i][ZW-1] : y_s[i][W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i+1] <= tag_s[i];
				if (op) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end
			end
		end
	end

	assign vld_out = vld_s[STAGES];
	assign x_out = x_s[STAGES];
	assign y_out = y_s[STAGES];
	assign z_out = z_s[STAGES];
	assign tag_out = tag_s[STAGES];

endmodule

>>> design/rotation_matrix_to_euler_unit.sv
// throughput: one matrix word per cycle unless held, set by unrolled cordic pipelines
// the whole pipeline holds while out_valid is high and out_stall is high
// arst_n clears all valid bits at once; data registers are not reset
`timescale 1ns / 1ps
module rotation_matrix_to_euler_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] r00,
	input  logic signed [15:0] r01,
	input  logic signed [15:0] r02,
	input  logic signed [15:0] r10,
	input  logic signed [15:0] r11,
	input  logic signed [15:0] r12,
	input  logic signed [15:0] r20,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] yaw_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] roll_angle
);
	import r2e_pkg::*;

	function automatic vec_t prerot(input logic signed [VW-1:0] x,
			input logic signed [VW-1:0] y);
		vec_t v;
		v.x = x;
		v.y = y;
		v.z = '0;
		if (x[VW-1]) begin
			if (!y[VW-1]) begin
				v.x = y;
				v.y = -x;
				v.z = HALF_PI_Q24;
			end else begin
				v.x = -y;
				v.y = x;
				v.z = -HALF_PI_Q24;
			end
		end
		return v;
	endfunction

	function automatic logic signed [MW-1:0] wrap13(input logic signed [ZW-1:0] z);
		logic signed [ZW:0]   t;
		logic signed [AW-1:0] a;
		t = {z[ZW-1], z} + (ZW+1)'(1024);
		a = AW'(t >>> 11);
		if (a >= PI_Q13) begin
			a = a - TWO_PI_Q13;
		end else if (a < -PI_Q13) begin
			a = a + TWO_PI_Q13;
		end
		return a[MW-1:0];
	endfunction

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: capture and pre-rotate yaw vector
	mat_t m_in;
	vec_t v_in;
	assign m_in = '{r00: r00, r01: r01, r02: r02, r10: r10, r11: r11, r12: r12, r20: r20};
	assign v_in = prerot(VW'(r00) <<< 16, VW'(r10) <<< 16);

	logic vld_s1;
	vec_t v_s1;
	logic zero_s1;
	mat_t m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v_in;
			zero_s1 <= (r00 == '0) && (r10 == '0);
			m_s1 <= m_in;
		end
	end

	// yaw cordic
	logic                 vld_y;
	logic signed [VW-1:0] x_y;
	logic signed [VW-1:0] y_y;
	logic signed [ZW-1:0] z_y;
	logic [$bits(mat_t):0] tag_y;

	r2e_cordic #(.STAGES(CORDIC_STAGES), .W(VW), .TW($bits(mat_t) + 1), .ROTATE(1'b0))
	u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s1),
		.x_in(v_s1.x), .y_in(v_s1.y), .z_in(v_s1.z), .tag_in({zero_s1, m_s1}),
		.vld_out(vld_y), .x_out(x_y), .y_out(y_y), .z_out(z_y), .tag_out(tag_y)
	);

	// stage 2: wrap yaw
	logic vld_s2;
	logic signed [MW-1:0] yaw_s2;
	mat_t m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s2 <= tag_y[$bits(mat_t)] ? '0 : wrap13(z_y);
			m_s2 <= tag_y[$bits(mat_t)-1:0];
		end
	end

	// stage 3: fold yaw into the half plane for sin and cos
	logic signed [ZW-1:0] zf;
	assign zf = ZW'(yaw_s2) <<< 11;

	logic vld_s3;
	logic signed [ZW-1:0] zf_s3;
	logic neg_s3;
	logic signed [MW-1:0] yaw_s3;
	mat_t m_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s3 <= yaw_s2;
			m_s3 <= m_s2;
			if (zf > HALF_PI_Q24) begin
				zf_s3 <= zf - PI_Q24;
				neg_s3 <= 1'b1;
			end else if (zf < -HALF_PI_Q24) begin
				zf_s3 <= zf + PI_Q24;
				neg_s3 <= 1'b1;
			end else begin
				zf_s3 <= zf;
				neg_s3 <= 1'b0;
			end
		end
	end

	// sin and cos cordic
	localparam int SCT = 1 + MW + $bits(mat_t);
	logic                 vld_r;
	logic signed [RW-1:0] x_r;
	logic signed [RW-1:0] y_r;
	logic signed [ZW-1:0] z_r;
	logic [SCT-1:0]       tag_r;

	r2e_cordic #(.STAGES(CORDIC_STAGES), .W(RW), .TW(SCT), .ROTATE(1'b1))
	u_sincos (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3),
		.x_in(KINV_Q30), .y_in('0), .z_in(zf_s3), .tag_in({neg_s3, yaw_s3, m_s3}),
		.vld_out(vld_r), .x_out(x_r), .y_out(y_r), .z_out(z_r), .tag_out(tag_r)
	);

	// stage 4: sign and round cos and sin
	logic signed [RW-1:0] xn;
	logic signed [RW-1:0] yn;
	logic signed [RW-1:0] c_full;
	logic signed [RW-1:0] s_full;
	assign xn = tag_r[SCT-1] ? -x_r : x_r;
	assign yn = tag_r[SCT-1] ? -y_r : y_r;
	assign c_full = (xn + RW'(8192)) >>> 14;
	assign s_full = (yn + RW'(8192)) >>> 14;

	logic vld_s4;
	logic signed [CW-1:0] c_s4;
	logic signed [CW-1:0] s_s4;
	logic signed [MW-1:0] yaw_s4;
	mat_t m_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= c_full[CW-1:0];
			s_s4 <= s_full[CW-1:0];
			yaw_s4 <= tag_r[SCT-2 -: MW];
			m_s4 <= tag_r[$bits(mat_t)-1:0];
		end
	end

	// stage 5: products
	logic vld_s5;
	logic signed [PW-1:0] p0_s5, p1_s5, p2_s5, p3_s5, p4_s5, p5_s5;
	logic signed [MW-1:0] r20_s5;
	logic signed [MW-1:0] yaw_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s5 <= PW'(m_s4.r00) * PW'(c_s4);
			p1_s5 <= PW'(m_s4.r10) * PW'(s_s4);
			p2_s5 <= PW'(m_s4.r02) * PW'(s_s4);
			p3_s5 <= PW'(m_s4.r12) * PW'(c_s4);
			p4_s5 <= PW'(m_s4.r11) * PW'(c_s4);
			p5_s5 <= PW'(m_s4.r01) * PW'(s_s4);
			r20_s5 <= m_s4.r20;
			yaw_s5 <= yaw_s4;
		end
	end

	// stage 6: pitch and roll operands
	logic vld_s6;
	logic signed [VW-1:0] xp_s6, yp_s6, xr_s6, yr_s6;
	logic signed [MW-1:0] yaw_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s6 <= VW'(p0_s5) + VW'(p1_s5);
			yp_s6 <= -(VW'(r20_s5) <<< 16);
			xr_s6 <= VW'(p4_s5) - VW'(p5_s5);
			yr_s6 <= VW'(p2_s5) - VW'(p3_s5);
			yaw_s6 <= yaw_s5;
		end
	end

	// stage 7: pre-rotate pitch and roll vectors
	logic vld_s7;
	vec_t vp_s7, vr_s7;
	logic zp_s7, zr_s7;
	logic signed [MW-1:0] yaw_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vp_s7 <= prerot(xp_s6, yp_s6);
			vr_s7 <= prerot(xr_s6, yr_s6);
			zp_s7 <= (xp_s6 == '0) && (yp_s6 == '0);
			zr_s7 <= (xr_s6 == '0) && (yr_s6 == '0);
			yaw_s7 <= yaw_s6;
		end
	end

	// pitch and roll cordics
	logic                 vld_p, vld_q;
	logic signed [VW-1:0] x_p, y_p, x_q, y_q;
	logic signed [ZW-1:0] z_p, z_q;
	logic [MW:0]          tag_p;
	logic                 tag_q;

	r2e_cordic #(.STAGES(CORDIC_STAGES), .W(VW), .TW(MW + 1), .ROTATE(1'b0))
	u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s7),
		.x_in(vp_s7.x), .y_in(vp_s7.y), .z_in(vp_s7.z), .tag_in({zp_s7, yaw_s7}),
		.vld_out(vld_p), .x_out(x_p), .y_out(y_p), .z_out(z_p), .tag_out(tag_p)
	);

	r2e_cordic #(.STAGES(CORDIC_STAGES), .W(VW), .TW(1), .ROTATE(1'b0))
	u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s7),
		.x_in(vr_s7.x), .y_in(vr_s7.y), .z_in(vr_s7.z), .tag_in(zr_s7),
		.vld_out(vld_q), .x_out(x_q), .y_out(y_q), .z_out(z_q), .tag_out(tag_q)
	);

	// stage 8: output word
	logic vld_s8;
	logic signed [MW-1:0] yaw_s8, pitch_s8, roll_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s8 <= tag_p[MW-1:0];
			pitch_s8 <= tag_p[MW] ? '0 : wrap13(z_p);
			roll_s8 <= tag_q ? '0 : wrap13(z_q);
		end
	end

	assign out_valid = vld_s8;
	assign yaw_angle = yaw_s8;
	assign pitch_angle = pitch_s8;
	assign roll_angle = roll_s8;

`ifndef SYNTH
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vld_p == vld_q)
		else $error("pitch and roll lanes out of step");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_angle >= -16'sd25736 && yaw_angle <= 16'sd25735))
		else $error("yaw out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle >= -16'sd25736 && pitch_angle <= 16'sd25735))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle >= -16'sd25736 && roll_angle <= 16'sd25735))
		else $error("roll out of range");

	a_zero_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_y && tag_y[$bits(mat_t)]) |=> (yaw_s2 == '0))
		else $error("zero vector gave nonzero yaw");
`endif

endmodule
